// ===== hdl/imusi_pkg.sv =====
package imusi_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int COUNT_BITS  = 17;
  localparam int MEAN_W      = SAMPLE_BITS + FRAC_BITS;
  localparam int VAR_W       = 2 * SAMPLE_BITS - 1 + FRAC_BITS;
  localparam int GRAV_W      = 32;
  localparam int LIMIT_W     = 16;
  localparam int GMAG_W      = 24;
  localparam int AXES        = 6;
  localparam int DIV_W       = 64;
  localparam int DIVR_W      = 32;
  localparam int ROOT_W      = 32;
  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;

  localparam logic [VAR_W-1:0]      VAR_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    REG_LIMIT  = 3'd0,
    REG_GMAG   = 3'd1,
    REG_ACC_X  = 3'd2,
    REG_ACC_Y  = 3'd3,
    REG_ACC_Z  = 3'd4,
    REG_GYR_X  = 3'd5,
    REG_GYR_Y  = 3'd6,
    REG_GYR_Z  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]          limit;
    logic [GMAG_W-1:0]           gmag;
    logic [2:0][VAR_W-1:0]       acc_set;
    logic [2:0][VAR_W-1:0]       gyr_set;
  } cfg_t;

endpackage

// ===== hdl/imusi_div.sv =====
module imusi_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [imusi_pkg::DIV_W-1:0]    dividend,
  input  logic [imusi_pkg::DIVR_W-1:0]   divisor,
  output logic                           done,
  output logic [imusi_pkg::DIV_W-1:0]    quot
);
  import imusi_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0]  acc;
  logic [DIVR_W:0]   rem;
  logic [DIVR_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIVR_W:0]   rem_sh;
  logic              fits;

  // one quotient bit a cycle, round to nearest via pre-added half divisor
  always_comb begin
    rem_sh = {rem[DIVR_W-1:0], acc[DIV_W-1]};
    fits   = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= dividend + DIV_W'(divisor >> 1);
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= rem_sh - {1'b0, dvs};
        end else begin
          rem <= rem_sh;
        end
        acc <= {acc[DIV_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = acc;

endmodule

// ===== hdl/imusi_sqrt.sv =====
module imusi_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [2*imusi_pkg::ROOT_W-1:0] radicand,
  output logic                          done,
  output logic [imusi_pkg::ROOT_W-1:0]  root
);
  import imusi_pkg::*;

  localparam int X_W = 2 * ROOT_W;

  logic [X_W-1:0] xr;
  logic [X_W-1:0] r;
  logic [X_W-1:0] bitm;
  logic           busy;
  logic [X_W-1:0] trial;

  assign trial = r + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xr   <= radicand;
        r    <= '0;
        bitm <= X_W'(1) << (X_W - 2);
        busy <= 1'b1;
      end else if (busy) begin
        if (xr >= trial) begin
          xr <= xr - trial;
          r  <= (r >> 1) + bitm;
        end else begin
          r  <= r >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = r[ROOT_W-1:0];

endmodule

// ===== hdl/imusi_cfg.sv =====
module imusi_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [imusi_pkg::ADDR_W-1:0] paddr,
  input  logic [imusi_pkg::DATA_W-1:0] pwdata,
  output logic [imusi_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output imusi_pkg::cfg_t              cfg
);
  import imusi_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit   <= LIMIT_W'(10);
      cfg.gmag    <= GMAG_W'(642908);
      cfg.acc_set <= '0;
      cfg.gyr_set <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_LIMIT: cfg.limit      <= pwdata[LIMIT_W-1:0];
        REG_GMAG:  cfg.gmag       <= pwdata[GMAG_W-1:0];
        REG_ACC_X: cfg.acc_set[0] <= pwdata[VAR_W-1:0];
        REG_ACC_Y: cfg.acc_set[1] <= pwdata[VAR_W-1:0];
        REG_ACC_Z: cfg.acc_set[2] <= pwdata[VAR_W-1:0];
        REG_GYR_X: cfg.gyr_set[0] <= pwdata[VAR_W-1:0];
        REG_GYR_Y: cfg.gyr_set[1] <= pwdata[VAR_W-1:0];
        REG_GYR_Z: cfg.gyr_set[2] <= pwdata[VAR_W-1:0];
        default:   cfg.limit      <= cfg.limit;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LIMIT: prdata = DATA_W'(cfg.limit);
      REG_GMAG:  prdata = DATA_W'(cfg.gmag);
      REG_ACC_X: prdata = DATA_W'(cfg.acc_set[0]);
      REG_ACC_Y: prdata = DATA_W'(cfg.acc_set[1]);
      REG_ACC_Z: prdata = DATA_W'(cfg.acc_set[2]);
      REG_GYR_X: prdata = DATA_W'(cfg.gyr_set[0]);
      REG_GYR_Y: prdata = DATA_W'(cfg.gyr_set[1]);
      REG_GYR_Z: prdata = DATA_W'(cfg.gyr_set[2]);
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== hdl/imu_static_init_statistics.sv =====
// results: each accepted sample gives an accelerometer result, while initializing after
//   the mean and variance updates, once done after the gravity step alone, whose divisions
//   are skipped when the accelerometer mean is zero; the gyro result follows once result_stall is low
// a new sample is stalled until both results are taken; the pace is set by the shared 64-step
//   divider (three divisions per axis, six axes, three for gravity) and the 32-step root
// reset (rst, synchronous): means and variances zero, count one, registers at defaults
module imu_static_init_statistics (
  input  logic                                clk,
  input  logic                                rst,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [imusi_pkg::ADDR_W-1:0]        paddr,
  input  logic [imusi_pkg::DATA_W-1:0]        pwdata,
  output logic [imusi_pkg::DATA_W-1:0]        prdata,
  output logic                                pready,
  // sample channel
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [imusi_pkg::SAMPLE_BITS-1:0] acc_x,
  input  logic signed [imusi_pkg::SAMPLE_BITS-1:0] acc_y,
  input  logic signed [imusi_pkg::SAMPLE_BITS-1:0] acc_z,
  input  logic signed [imusi_pkg::SAMPLE_BITS-1:0] gyr_x,
  input  logic signed [imusi_pkg::SAMPLE_BITS-1:0] gyr_y,
  input  logic signed [imusi_pkg::SAMPLE_BITS-1:0] gyr_z,
  input  logic                                group_end,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                sensor_kind,
  output logic signed [imusi_pkg::MEAN_W-1:0] mean_x,
  output logic signed [imusi_pkg::MEAN_W-1:0] mean_y,
  output logic signed [imusi_pkg::MEAN_W-1:0] mean_z,
  output logic [imusi_pkg::VAR_W-1:0]         var_x,
  output logic [imusi_pkg::VAR_W-1:0]         var_y,
  output logic [imusi_pkg::VAR_W-1:0]         var_z,
  output logic signed [imusi_pkg::GRAV_W-1:0] gravity_x,
  output logic signed [imusi_pkg::GRAV_W-1:0] gravity_y,
  output logic signed [imusi_pkg::GRAV_W-1:0] gravity_z,
  output logic                                init_done,
  output logic                                last_result
);
  import imusi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_MDIV, S_SQ, S_UDIV, S_VDIV1, S_VADD, S_VDIV2,
    S_COUNT, S_SSQ, S_SACC, S_ROOT, S_RWAIT, S_GMUL, S_GDIV, S_GWAIT,
    S_OUT_ACC, S_OUT_GYR
  } state_t;

  state_t state;

  cfg_t cfg;

  // per-axis state, accelerometer in slots 0..2, gyro in 3..5
  logic [AXES-1:0][SAMPLE_BITS-1:0] smp;
  logic [AXES-1:0][MEAN_W-1:0]      mean;
  logic [AXES-1:0][VAR_W-1:0]       var_r;
  logic [2:0][GRAV_W-1:0]           grav;
  logic [COUNT_BITS-1:0]            count;
  logic                             done_flag;
  logic                             gend;

  logic [2:0]           ax;
  logic [1:0]           gi;
  logic                 neg;
  logic [DIV_W-1:0]     prod;
  logic [DIV_W-1:0]     wreg;
  logic [DIV_W-1:0]     sumsq;
  logic [ROOT_W-1:0]    norm;

  // shared multiplier, divider and root
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [63:0]          mul_p;
  logic                 div_start;
  logic [DIV_W-1:0]     div_a;
  logic [DIVR_W-1:0]    div_b;
  logic                 div_done;
  logic [DIV_W-1:0]     div_q;
  logic                 sqrt_start;
  logic                 sqrt_done;
  logic [ROOT_W-1:0]    sqrt_root;

  logic                         accept;
  logic signed [MEAN_W-1:0]     xq;
  logic signed [MEAN_W-1:0]     mcur;
  logic signed [MEAN_W+1:0]     diff;
  logic [MEAN_W:0]              adiff;
  logic [MEAN_W+1:0]            q34;
  logic [MEAN_W+1:0]            mnew;
  logic [MEAN_W-1:0]            gmag_m;
  logic [DIV_W-1:0]             w2;
  logic [COUNT_BITS-1:0]        count_new;

  imusi_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  imusi_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(div_q)
  );

  imusi_sqrt u_sqrt (
    .clk, .rst, .start(sqrt_start), .radicand(sumsq), .done(sqrt_done),
    .root(sqrt_root)
  );

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = (state != S_IDLE);
  assign result_valid = (state == S_OUT_ACC) || (state == S_OUT_GYR);

  // sample in Q.16 and the signed distance to the current mean
  always_comb begin
    xq    = {smp[ax], {FRAC_BITS{1'b0}}};
    mcur  = mean[ax];
    diff  = {{2{xq[MEAN_W-1]}}, xq} - {{2{mcur[MEAN_W-1]}}, mcur};
    adiff = diff[MEAN_W+1] ? MEAN_W'(1) + (MEAN_W+1)'(~diff) : diff[MEAN_W:0];
    q34   = div_q[MEAN_W+1:0];
    mnew  = {{2{mcur[MEAN_W-1]}}, mcur} + (neg ? (~q34 + 1'b1) : q34);
    gmag_m = mean[gi][MEAN_W-1] ? (~mean[gi] + 1'b1) : mean[gi];
    w2    = wreg - div_q;
    count_new = (count != COUNT_MAX) ? count + 1'b1 : count;
  end

  // operand select for the shared units
  always_comb begin
    mul_a      = adiff[31:0];
    mul_b      = adiff[31:0];
    div_a      = DIV_W'(adiff);
    div_b      = DIVR_W'(count);
    div_start  = 1'b0;
    sqrt_start = (state == S_ROOT);
    unique case (state)
      S_SSQ: begin
        mul_a = gmag_m;
        mul_b = gmag_m;
      end
      S_GMUL: begin
        mul_a = gmag_m;
        mul_b = 32'(cfg.gmag);
      end
      S_DIFF: div_start = 1'b1;
      S_UDIV: begin
        div_start = 1'b1;
        div_a     = (prod + DIV_W'(64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      end
      S_VADD: begin
        div_start = 1'b1;
        div_a     = DIV_W'(var_r[ax]) + div_q;
      end
      S_GDIV: begin
        div_start = 1'b1;
        div_a     = prod;
        div_b     = norm;
      end
      default: div_start = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mean      <= '0;
      var_r     <= '0;
      count     <= COUNT_BITS'(1);
      done_flag <= 1'b0;
      ax        <= '0;
      gi        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            smp   <= {gyr_z, gyr_y, gyr_x, acc_z, acc_y, acc_x};
            gend  <= group_end;
            ax    <= '0;
            gi    <= '0;
            sumsq <= '0;
            state <= done_flag ? S_SSQ : S_DIFF;
          end
        end
        // mean += round((x - mean) / n)
        S_DIFF: begin
          neg   <= diff[MEAN_W+1];
          state <= S_MDIV;
        end
        S_MDIV: begin
          if (div_done) begin
            mean[ax] <= mnew[MEAN_W-1:0];
            state    <= S_SQ;
          end
        end
        // squared distance of the sample to the updated mean
        S_SQ: begin
          prod  <= mul_p;
          state <= S_UDIV;
        end
        S_UDIV: state <= S_VDIV1;
        S_VDIV1: begin
          if (div_done) begin
            state <= S_VADD;
          end
        end
        S_VADD: begin
          wreg  <= DIV_W'(var_r[ax]) + div_q;
          state <= S_VDIV2;
        end
        S_VDIV2: begin
          if (div_done) begin
            var_r[ax] <= (w2 > DIV_W'(VAR_MAX)) ? VAR_MAX : w2[VAR_W-1:0];
            if (ax == 3'(AXES - 1)) begin
              state <= S_COUNT;
            end else begin
              ax    <= ax + 1'b1;
              state <= S_DIFF;
            end
          end
        end
        S_COUNT: begin
          count <= count_new;
          if (gend && (count_new > COUNT_BITS'(cfg.limit))) begin
            done_flag <= 1'b1;
            var_r     <= {cfg.gyr_set, cfg.acc_set};
          end
          state <= S_SSQ;
        end
        // sum of squares of the accelerometer mean
        S_SSQ: begin
          prod  <= mul_p;
          state <= S_SACC;
        end
        S_SACC: begin
          sumsq <= sumsq + prod;
          if (gi == 2'd2) begin
            gi    <= '0;
            state <= S_ROOT;
          end else begin
            gi    <= gi + 1'b1;
            state <= S_SSQ;
          end
        end
        S_ROOT: state <= S_RWAIT;
        S_RWAIT: begin
          if (sqrt_done) begin
            norm <= sqrt_root;
            if (sqrt_root == '0) begin
              grav  <= '0;
              state <= S_OUT_ACC;
            end else begin
              state <= S_GMUL;
            end
          end
        end
        // gravity = -mean / |mean| * g, one axis at a time
        S_GMUL: begin
          prod  <= mul_p;
          state <= S_GDIV;
        end
        S_GDIV: state <= S_GWAIT;
        S_GWAIT: begin
          if (div_done) begin
            grav[gi] <= mean[gi][MEAN_W-1] ? div_q[GRAV_W-1:0]
                                           : (~div_q[GRAV_W-1:0] + 1'b1);
            if (gi == 2'd2) begin
              state <= S_OUT_ACC;
            end else begin
              gi    <= gi + 1'b1;
              state <= S_GMUL;
            end
          end
        end
        S_OUT_ACC: begin
          if (!result_stall) begin
            state <= S_OUT_GYR;
          end
        end
        S_OUT_GYR: begin
          if (!result_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result fields straight from the state registers
  always_comb begin
    sensor_kind = (state == S_OUT_GYR);
    last_result = (state == S_OUT_GYR);
    init_done   = done_flag;
    if (state == S_OUT_GYR) begin
      mean_x    = mean[3];
      mean_y    = mean[4];
      mean_z    = mean[5];
      var_x     = var_r[3];
      var_y     = var_r[4];
      var_z     = var_r[5];
      gravity_x = '0;
      gravity_y = '0;
      gravity_z = '0;
    end else begin
      mean_x    = mean[0];
      mean_y    = mean[1];
      mean_z    = mean[2];
      var_x     = var_r[0];
      var_y     = var_r[1];
      var_z     = var_r[2];
      gravity_x = grav[0];
      gravity_y = grav[1];
      gravity_z = grav[2];
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done_flag |=> done_flag) else $error("done flag cleared");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    count != '0) else $error("sample count reached zero");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sample_stall) else $error("sample taken while results pending");

  a_frozen_after_done: assert property (@(posedge clk) disable iff (rst)
    ($past(done_flag) && done_flag) |-> $stable(count))
    else $error("count moved after done");

endmodule
